// File: rtl/float_to_decimal_text_assert.svh
// Assertion macros used by the top block of the float to text converter.
`ifndef FLOAT_TO_DECIMAL_TEXT_ASSERT_SVH
`define FLOAT_TO_DECIMAL_TEXT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define F2D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define F2D_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/f2d_pkg.sv
package f2d_pkg;

  // Text limits.
  localparam int TEXT_BUFFER_LEN = 15;
  localparam int MAX_CHARS       = 14;
  localparam int MAX_FRAC_DIGITS = 7;
  localparam int INT_DIGITS      = 10;
  localparam int BUF_ROOM        = (TEXT_BUFFER_LEN - 1 < MAX_CHARS) ?
                                   (TEXT_BUFFER_LEN - 1) : MAX_CHARS;
  localparam int REG_PLACES      = 4;

  // Biased exponent thresholds.
  localparam logic [7:0] EXP_BIAS_M1   = 8'd126;
  localparam logic [7:0] EXP_BIAS      = 8'd127;
  localparam logic [7:0] EXP_NO_FRAC   = 8'd150;
  localparam logic [7:0] EXP_TOO_LARGE = 8'd158;
  localparam logic [7:0] EXP_TOO_SMALL = 8'd104;

  // ASCII characters.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_TOO_SMALL = 2'd2
  } status_t;

  // Fields pulled from the float pattern when a conversion starts.
  typedef struct packed {
    logic        neg;
    status_t     status;
    logic [4:0]  iters;
    logic [23:0] mant;
    logic [23:0] frac;
  } decode_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic       load;
    logic       dabble;
    logic       frac_step;
    logic [3:0] int_sel;
    logic [2:0] frac_sel;
  } dp_ctl_t;

  // Results from the datapath back to the sequencer.
  typedef struct packed {
    logic [3:0] ndig;
    logic [2:0] keep;
    logic       frac_zero;
    logic [3:0] int_digit;
    logic [3:0] frac_digit;
  } dp_stat_t;

  // Characters of the error text.
  function automatic logic [7:0] err_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h66;
      3'd1: c = 8'h74;
      3'd2: c = 8'h6F;
      3'd3: c = 8'h61;
      3'd4: c = 8'h20;
      3'd5: c = 8'h45;
      default: c = 8'h52;
    endcase
    return c;
  endfunction

  // Classify the pattern, and split the significand into its integer bit
  // count and a 24-bit binary fraction.
  function automatic decode_t decode(input logic [31:0] bits);
    decode_t     d;
    logic [7:0]  expf;
    logic [5:0]  sh;
    logic [47:0] wide;
    expf     = bits[30:23];
    d.mant   = {1'b1, bits[22:0]};
    d.neg    = 1'b0;
    d.status = STATUS_OK;
    d.iters  = '0;
    d.frac   = '0;
    sh       = '0;
    wide     = '0;
    if (bits[30:0] == 31'd0) begin
      // Both zeros fall through as an empty integer and empty fraction.
      d.status = STATUS_OK;
    end else if (expf >= EXP_TOO_LARGE) begin
      d.status = STATUS_TOO_LARGE;
    end else if (expf < EXP_TOO_SMALL) begin
      d.status = STATUS_TOO_SMALL;
    end else begin
      d.neg = bits[31];
      if (expf >= EXP_BIAS) begin
        d.iters = 5'(expf - EXP_BIAS_M1);
      end
      if (expf < EXP_NO_FRAC) begin
        sh     = 6'(EXP_NO_FRAC - expf);
        wide   = {d.mant, 24'd0} >> sh;
        d.frac = wide[23:0];
      end
    end
    return d;
  endfunction

endpackage

// File: rtl/f2d_datapath.sv
module f2d_datapath (
  input  logic               clk,
  input  f2d_pkg::dp_ctl_t   ctl,
  input  f2d_pkg::decode_t   dec,
  output f2d_pkg::dp_stat_t  stat
);

  logic [30:0]      src;
  logic [9:0][3:0]  bcd;
  logic [9:0][3:0]  bcd_adj;
  logic [23:0]      frac;
  logic             frac_zero;
  logic [2:0]       keep;
  logic [3:0]       fdig [f2d_pkg::MAX_FRAC_DIGITS];
  logic [27:0]      prod;
  logic [3:0]       ndig;

  // Double-dabble correction: each BCD digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < f2d_pkg::INT_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
  end

  // Fraction times ten: the carry out above bit 23 is the next decimal digit.
  assign prod = {1'b0, frac, 3'd0} + {3'd0, frac, 1'd0};

  // Count of significant integer digits, at least one.
  always_comb begin
    ndig = 4'd1;
    for (int i = 1; i < f2d_pkg::INT_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
  end

  // Shared iteration registers.
  // A 31-bit integer never reaches the top bit of the tenth digit, so the
  // shift drops it.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      src       <= {dec.mant, 7'd0};
      bcd       <= '0;
      frac      <= dec.frac;
      frac_zero <= (dec.frac == 24'd0);
      keep      <= '0;
    end else if (ctl.dabble) begin
      bcd <= {bcd_adj[9][2:0], bcd_adj[8:0], src[30]};
      src <= {src[29:0], 1'b0};
    end else if (ctl.frac_step) begin
      frac                <= prod[23:0];
      fdig[ctl.frac_sel]  <= prod[27:24];
      if (prod[27:24] != 4'd0) begin
        keep <= ctl.frac_sel + 3'd1;
      end
    end
  end

  assign stat.ndig       = ndig;
  assign stat.keep       = keep;
  assign stat.frac_zero  = frac_zero;
  assign stat.int_digit  = bcd[ctl.int_sel];
  assign stat.frac_digit = fdig[ctl.frac_sel];

endmodule

// File: rtl/float_to_decimal_text.sv
// Float to decimal text converter. A start beat, taken when busy is low,
// hands over one IEEE single pattern; the block then sends its decimal text
// one ASCII character per cycle on out_char, each marked by a one-cycle
// char_valid strobe, with last_char on the final character and the same
// conv_status on every character. The receiver cannot stall: every strobed
// character must be taken in its cycle. A conversion walks its integer bits
// (0 to 31) through the double-dabble unit one bit per cycle, sets the
// fraction digit budget, makes its fractional digits (0 to 7) in the
// times-ten unit one digit per cycle, then sends the text; out-of-range
// values send an error text. busy stays high from the start beat until
// the last character is sent. The user must write frac_places through
// cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
`include "float_to_decimal_text_assert.svh"

module float_to_decimal_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] float_bits,
  output logic        busy,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  output logic        char_valid,
  output logic [7:0]  out_char,
  output logic        last_char,
  output logic [1:0]  conv_status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INT,
    S_PREP,
    S_FRAC,
    S_SIGN,
    S_IDIG,
    S_DOT,
    S_FDIG,
    S_ERR
  } state_t;

  localparam logic [4:0] BufRoom   = 5'(f2d_pkg::BUF_ROOM);
  localparam logic [2:0] MaxFrac   = 3'(f2d_pkg::MAX_FRAC_DIGITS);

  state_t             state;
  logic [4:0]         idx;
  logic [2:0]         frac_places;
  logic               neg;
  logic [3:0]         ndig;
  logic [2:0]         lim;

  f2d_pkg::decode_t   dec;
  f2d_pkg::dp_ctl_t   ctl;
  f2d_pkg::dp_stat_t  stat;

  logic [4:0]         nb;
  logic [4:0]         room;
  logic [2:0]         lim_c;
  logic [2:0]         fcount;

  assign dec  = f2d_pkg::decode(float_bits);
  assign busy = (state != S_IDLE);

  // Datapath commands.
  always_comb begin
    ctl.load      = (state == S_IDLE) && start;
    ctl.dabble    = (state == S_INT);
    ctl.frac_step = (state == S_FRAC);
    ctl.int_sel   = idx[3:0];
    ctl.frac_sel  = idx[2:0];
  end

  f2d_datapath u_dp (
    .clk  (clk),
    .ctl  (ctl),
    .dec  (dec),
    .stat (stat)
  );

  // Fraction digit budget: room left after sign, integer digits and point, capped by MAX_FRAC_DIGITS and frac_places.
  always_comb begin
    nb    = 5'({4'd0, neg}) + {1'b0, stat.ndig} + 5'd1;
    room  = (nb >= BufRoom) ? 5'd0 : (BufRoom - nb);
    lim_c = (room > {2'd0, MaxFrac}) ? MaxFrac : room[2:0];
    if (lim_c > frac_places) begin
      lim_c = frac_places;
    end
  end

  // Fraction digits sent, after trailing zeros are dropped.
  always_comb begin
    if (stat.frac_zero) begin
      fcount = 3'd1;
    end else if (lim == 3'd0) begin
      fcount = 3'd0;
    end else if (stat.keep == 3'd0) begin
      fcount = 3'd1;
    end else begin
      fcount = stat.keep;
    end
  end

  // Sequencer and registered character output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      frac_places <= 3'(f2d_pkg::REG_PLACES);
      char_valid  <= 1'b0;
      last_char   <= 1'b0;
    end else begin
      char_valid <= 1'b0;
      last_char  <= 1'b0;
      if (cfg_wr_en) begin
        frac_places <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            neg         <= dec.neg;
            conv_status <= dec.status;
            if (dec.status != f2d_pkg::STATUS_OK) begin
              state <= S_ERR;
              idx   <= '0;
            end else if (dec.iters == 5'd0) begin
              state <= S_PREP;
            end else begin
              state <= S_INT;
              idx   <= dec.iters;
            end
          end
        end
        S_INT: begin
          idx <= idx - 5'd1;
          if (idx == 5'd1) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          ndig <= stat.ndig;
          lim  <= lim_c;
          if (!stat.frac_zero && (lim_c != 3'd0)) begin
            state <= S_FRAC;
            idx   <= '0;
          end else begin
            state <= neg ? S_SIGN : S_IDIG;
            idx   <= {1'b0, stat.ndig - 4'd1};
          end
        end
        S_FRAC: begin
          if (idx[2:0] == lim - 3'd1) begin
            state <= neg ? S_SIGN : S_IDIG;
            idx   <= {1'b0, ndig - 4'd1};
          end else begin
            idx <= idx + 5'd1;
          end
        end
        S_SIGN: begin
          char_valid <= 1'b1;
          out_char   <= f2d_pkg::CHAR_MINUS;
          state      <= S_IDIG;
          idx        <= {1'b0, ndig - 4'd1};
        end
        S_IDIG: begin
          char_valid <= 1'b1;
          out_char   <= f2d_pkg::CHAR_ZERO + {4'd0, stat.int_digit};
          if (idx == 5'd0) begin
            state <= S_DOT;
          end else begin
            idx <= idx - 5'd1;
          end
        end
        S_DOT: begin
          char_valid <= 1'b1;
          out_char   <= f2d_pkg::CHAR_DOT;
          if (fcount == 3'd0) begin
            last_char <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_FDIG;
            idx   <= '0;
          end
        end
        S_FDIG: begin
          char_valid <= 1'b1;
          out_char   <= stat.frac_zero ? f2d_pkg::CHAR_ZERO :
                        (f2d_pkg::CHAR_ZERO + {4'd0, stat.frac_digit});
          if (idx[2:0] == fcount - 3'd1) begin
            last_char <= 1'b1;
            state     <= S_IDLE;
          end else begin
            idx <= idx + 5'd1;
          end
        end
        S_ERR: begin
          char_valid <= 1'b1;
          out_char   <= f2d_pkg::err_char(idx[2:0]);
          if (idx[2:0] == 3'd7) begin
            last_char <= 1'b1;
            state     <= S_IDLE;
          end else begin
            idx <= idx + 5'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and the result stream.
  `F2D_ASSERT_IMP(a_last_has_valid, clk, rst, last_char, char_valid, "last_char without strobe")
  `F2D_ASSERT_IMP(a_busy_mid_text, clk, rst, char_valid && !last_char, busy, "idle mid-text")
  `F2D_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy, "accepted start left block idle")
  `F2D_ASSERT_IMP(a_status_code, clk, rst, char_valid, conv_status == f2d_pkg::STATUS_OK || conv_status == f2d_pkg::STATUS_TOO_LARGE || conv_status == f2d_pkg::STATUS_TOO_SMALL, "bad status")

endmodule
